>>> src/ctc_pkg.sv
`timescale 1ns / 1ps

package ctc_pkg;

  // Width of the set and elapsed time counters.
  localparam int TIME_BITS = 16;

  localparam int OP_W       = 3;
  localparam int SUB_W      = 4;
  localparam int MODE_W     = 3;
  localparam int REM_W      = 16;
  localparam int PROD_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int STEP_W     = 12;
  localparam int HOLD_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  // Room for a set time plus one step without losing the carry.
  localparam int SUM_W = ((TIME_BITS > STEP_W) ? TIME_BITS : STEP_W) + 1;

  // Output queue depth, and the width of its pointers and its fill count.
  localparam int QUEUE_DEPTH = 3;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_INC   = 3'd0;
  localparam logic [OP_W-1:0] OP_DEC   = 3'd1;
  localparam logic [OP_W-1:0] OP_START = 3'd2;
  localparam logic [OP_W-1:0] OP_ABORT = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_IGNORED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HANDLED    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TRANSITION = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 1'd1;

  localparam logic [STEP_W-1:0] STEP_RESET = 12'd60;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd30;

  localparam logic [SUB_W-1:0] SUB_BEEP   = 4'd5;
  localparam logic [SUB_W-1:0] SUB_SECOND = 4'd10;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [REM_W-1:0]    remaining;
    logic [PROD_W-1:0]   productive;
    logic                beep;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

>>> src/ctc_core.sv
`timescale 1ns / 1ps

module ctc_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                         item_valid,
  input  logic [ctc_pkg::OP_W-1:0]     operation,
  input  logic [ctc_pkg::SUB_W-1:0]    tick_subsecond,
  output ctc_pkg::result_t             result
);
  import ctc_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    IDLE      = 3'd0,
    SETTING   = 3'd1,
    COUNTDOWN = 3'd2,
    PAUSED    = 3'd3,
    STATS     = 3'd4
  } mode_t;

  logic [STEP_W-1:0]    step_seconds;
  logic [HOLD_W-1:0]    stat_hold_ticks;
  mode_t                mode_reg, mode_next;
  logic [TIME_BITS-1:0] set_time, set_time_next;
  logic [TIME_BITS-1:0] elapsed_seconds, elapsed_next;
  logic [PROD_W-1:0]    productive_total, productive_next;
  logic [HOLD_W-1:0]    stat_tick_count, stat_tick_next;

  logic [SUM_W-1:0]     set_ext, step_ext, add_sum, sub_diff;
  logic                 can_add, can_sub;
  logic                 take;
  mode_t                target;
  logic [STATUS_W-1:0]  status;
  logic                 beep;

  assign set_ext  = SUM_W'(set_time);
  assign step_ext = SUM_W'(step_seconds);
  assign add_sum  = set_ext + step_ext;
  assign sub_diff = set_ext - step_ext;
  assign can_add  = add_sum <= SUM_W'({TIME_BITS{1'b1}});
  assign can_sub  = set_ext >= step_ext;

  always_comb begin
    set_time_next   = set_time;
    elapsed_next    = elapsed_seconds;
    productive_next = productive_total;
    stat_tick_next  = stat_tick_count;
    mode_next       = mode_reg;
    take            = 1'b0;
    target          = mode_reg;
    status          = ST_IGNORED;
    beep            = 1'b0;

    case (mode_reg)
      IDLE: begin
        if (operation == OP_INC) begin
          if (can_add) begin
            set_time_next = add_sum[TIME_BITS-1:0];
            take          = 1'b1;
            target        = SETTING;
          end
        end else if (operation == OP_START) begin
          take   = 1'b1;
          target = STATS;
        end else if (operation == OP_TICK && tick_subsecond == SUB_BEEP) begin
          beep   = 1'b1;
          status = ST_HANDLED;
        end
      end
      SETTING: begin
        if (operation == OP_INC) begin
          if (can_add) begin
            set_time_next = add_sum[TIME_BITS-1:0];
            status        = ST_HANDLED;
          end
        end else if (operation == OP_DEC) begin
          if (can_sub) begin
            set_time_next = sub_diff[TIME_BITS-1:0];
            status        = ST_HANDLED;
          end
        end else if (operation == OP_START) begin
          if (can_sub && set_time != '0) begin
            take   = 1'b1;
            target = COUNTDOWN;
          end
        end else if (operation == OP_ABORT) begin
          take   = 1'b1;
          target = IDLE;
        end
      end
      COUNTDOWN: begin
        if (operation == OP_TICK) begin
          if (tick_subsecond == SUB_SECOND) begin
            if (set_time != '0) begin
              set_time_next = set_time - 1'b1;
            end
            elapsed_next = elapsed_seconds + 1'b1;
            if (set_time <= TIME_BITS'(1)) begin
              take   = 1'b1;
              target = IDLE;
            end else begin
              status = ST_HANDLED;
            end
          end
        end else if (operation == OP_START) begin
          take   = 1'b1;
          target = PAUSED;
        end else if (operation == OP_ABORT) begin
          take   = 1'b1;
          target = IDLE;
        end
      end
      PAUSED: begin
        if (operation == OP_INC) begin
          if (can_add) begin
            set_time_next = add_sum[TIME_BITS-1:0];
            take          = 1'b1;
            target        = SETTING;
          end
        end else if (operation == OP_DEC) begin
          if (can_sub) begin
            set_time_next = sub_diff[TIME_BITS-1:0];
            take          = 1'b1;
            target        = SETTING;
          end
        end else if (operation == OP_START) begin
          take   = 1'b1;
          target = COUNTDOWN;
        end else if (operation == OP_ABORT) begin
          take   = 1'b1;
          target = IDLE;
        end
      end
      STATS: begin
        if (operation == OP_TICK) begin
          stat_tick_next = stat_tick_count + 1'b1;
          if (stat_tick_next >= stat_hold_ticks) begin
            stat_tick_next = '0;
            take           = 1'b1;
            target         = IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    // Exit action of the old state, then entry action of the new one.
    if (take) begin
      if (mode_reg == COUNTDOWN) begin
        productive_next = productive_total + PROD_W'(elapsed_next);
        elapsed_next    = '0;
      end
      mode_next = target;
      if (target == IDLE) begin
        set_time_next = '0;
        elapsed_next  = '0;
      end
      status = ST_TRANSITION;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_seconds     <= STEP_RESET;
      stat_hold_ticks  <= HOLD_RESET;
      mode_reg         <= IDLE;
      set_time         <= '0;
      elapsed_seconds  <= '0;
      productive_total <= '0;
      stat_tick_count  <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_STEP) begin
          step_seconds <= cfg_data[STEP_W-1:0];
        end else if (cfg_index == CFG_HOLD) begin
          stat_hold_ticks <= cfg_data[HOLD_W-1:0];
        end
      end
      if (item_valid) begin
        mode_reg         <= mode_next;
        set_time         <= set_time_next;
        elapsed_seconds  <= elapsed_next;
        productive_total <= productive_next;
        stat_tick_count  <= stat_tick_next;
      end
    end
  end

  assign result.mode       = MODE_W'(mode_next);
  assign result.remaining  = REM_W'(set_time_next);
  assign result.productive = productive_next;
  assign result.beep       = beep;
  assign result.status     = status;

endmodule

>>> src/countdown_timer_controller_top.sv
`timescale 1ns / 1ps

// Countdown timer controller.
// Each request on the input channel (in_valid / in_stall) carries one event:
// increment, decrement, start or pause, abort, or a sub-second tick with its
// phase. Every request yields exactly one result on the output channel
// (out_valid / out_stall): the mode after the event, the set or remaining
// time, the running productive total, a beep request and a status code.
// The step size and the statistics hold count are written through the
// cfg_write / cfg_index / cfg_data port; the user must write them only
// while no request is in flight, as the block does not enforce it.
// A request is captured in an input register at the edge it is accepted;
// the state update then computes its result, which is written into a
// three-entry output queue once the queue has, or is freeing, a slot.
// One request per cycle is sustained as long as the receiver keeps
// taking results; the rate is set by the state update feeding the queue.
// When the receiver stalls, results wait in the queue and in_stall rises
// once the queue and the input register together hold three requests.
// A synchronous reset empties the queue, drops any captured request,
// returns the timer to idle with zero times and zero productive total, and
// restores the default step of 60 seconds and hold of 30 ticks.

module countdown_timer_controller_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ctc_pkg::OP_W-1:0]        operation,
  input  logic [ctc_pkg::SUB_W-1:0]       tick_subsecond,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ctc_pkg::MODE_W-1:0]      mode,
  output logic [ctc_pkg::REM_W-1:0]       remaining_seconds,
  output logic [ctc_pkg::PROD_W-1:0]      productive_seconds,
  output logic                            beep,
  output logic [ctc_pkg::STATUS_W-1:0]    status
);
  import ctc_pkg::*;

  // Input register.
  logic             req_valid;
  logic [OP_W-1:0]  req_op;
  logic [SUB_W-1:0] req_sub;

  // Output queue.
  result_t           queue [QUEUE_DEPTH];
  logic [QCNT_W-1:0] head, tail, count;

  logic    in_take, advance, pop;
  result_t result;

  assign in_take = in_valid && !in_stall;
  assign pop     = out_valid && !out_stall;
  // The captured request moves on whenever the queue has, or is freeing, a slot.
  assign advance = req_valid && (count != QCNT_W'(QUEUE_DEPTH) || pop);

  // Stall looks only at registered occupancy, so it never waits on out_stall.
  assign in_stall = ((QCNT_W+1)'(count) + (QCNT_W+1)'(req_valid)) >=
                    (QCNT_W+1)'(QUEUE_DEPTH);

  ctc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (advance),
    .operation      (req_op),
    .tick_subsecond (req_sub),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
    end else begin
      if (in_take) begin
        req_valid <= 1'b1;
      end else if (advance) begin
        req_valid <= 1'b0;
      end
      if (advance) begin
        tail <= (tail == QCNT_W'(QUEUE_DEPTH - 1)) ? QCNT_W'(0) : tail + QCNT_W'(1);
      end
      if (pop) begin
        head <= (head == QCNT_W'(QUEUE_DEPTH - 1)) ? QCNT_W'(0) : head + QCNT_W'(1);
      end
      if (advance && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !advance) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_op  <= operation;
      req_sub <= tick_subsecond;
    end
    if (advance) begin
      queue[tail] <= result;
    end
  end

  assign out_valid          = count != QCNT_W'(0);
  assign mode               = queue[head].mode;
  assign remaining_seconds  = queue[head].remaining;
  assign productive_seconds = queue[head].productive;
  assign beep               = queue[head].beep;
  assign status             = queue[head].status;

`ifndef SYNTHESIS
  // The queue never holds more results than it has slots.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("output queue overfilled");

  // A full queue always holds off new requests.
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (count == QCNT_W'(QUEUE_DEPTH)) |-> in_stall)
    else $error("request taken with a full output queue");

  // A request that moves on shows up as a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("request lost between input register and queue");

  // A beep is only ever reported with a handled status.
  a_beep_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && beep) |-> (status == ST_HANDLED))
    else $error("beep reported with wrong status");
`endif

endmodule
